// ===== src/bfsam_pkg.sv =====
// Shared types and constants for the breadth-first search block.
package bfsam_pkg;

    localparam int VtxW   = 5;
    localparam int RowW   = 32;
    localparam int CountW = 6;
    localparam int UpcW   = 4;
    localparam logic [CountW-1:0] CountReset = 6'd32;

    typedef struct packed {
        logic            cmd;
        logic [VtxW-1:0] row_index;
        logic [RowW-1:0] row_bits;
        logic [VtxW-1:0] start_vertex;
    } t_in_item;

    typedef struct packed {
        logic [VtxW-1:0] vertex;
        logic            last;
        logic            error;
    } t_out_item;

    // Input command codes.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_START = 1'b1;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_INIT,
        OP_QREAD,
        OP_ROWRD,
        OP_SCAN,
        OP_FIN,
        OP_ERR
    } t_op;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_START,
        C_BAD,
        C_QEMPTY,
        C_CAND
    } t_cond;

    typedef struct packed {
        logic            in_rdy;
        t_op             op;
        t_cond           cond;
        logic [UpcW-1:0] target;
    } t_ctrl;

    typedef struct packed {
        logic start_acc;
        logic bad;
        logic q_empty;
        logic cand;
        logic stall;
    } t_stat;

endpackage

// ===== src/bfsam_seq.sv =====
// Microcode sequencer: step counter, control ROM and conditional jumps.
module bfsam_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bfsam_pkg::t_stat i_stat,
    output bfsam_pkg::t_ctrl o_ctrl
);
    import bfsam_pkg::*;

    localparam logic [UpcW-1:0] StWait = 4'd0;
    localparam logic [UpcW-1:0] StChk  = 4'd1;
    localparam logic [UpcW-1:0] StInit = 4'd2;
    localparam logic [UpcW-1:0] StDeq  = 4'd3;
    localparam logic [UpcW-1:0] StRow  = 4'd4;
    localparam logic [UpcW-1:0] StScan = 4'd5;
    localparam logic [UpcW-1:0] StBack = 4'd6;
    localparam logic [UpcW-1:0] StFin  = 4'd7;
    localparam logic [UpcW-1:0] StErr  = 4'd8;

    function automatic t_ctrl step_word(input logic [UpcW-1:0] upc);
        t_ctrl w;
        case (upc)
            StWait:  w = '{in_rdy: 1'b1, op: OP_NONE,  cond: C_NO_START, target: StWait};
            StChk:   w = '{in_rdy: 1'b0, op: OP_NONE,  cond: C_BAD,      target: StErr};
            StInit:  w = '{in_rdy: 1'b0, op: OP_INIT,  cond: C_NEVER,    target: StWait};
            StDeq:   w = '{in_rdy: 1'b0, op: OP_QREAD, cond: C_QEMPTY,   target: StFin};
            StRow:   w = '{in_rdy: 1'b0, op: OP_ROWRD, cond: C_NEVER,    target: StWait};
            StScan:  w = '{in_rdy: 1'b0, op: OP_SCAN,  cond: C_CAND,     target: StScan};
            StBack:  w = '{in_rdy: 1'b0, op: OP_NONE,  cond: C_ALWAYS,   target: StDeq};
            StFin:   w = '{in_rdy: 1'b0, op: OP_FIN,   cond: C_ALWAYS,   target: StWait};
            StErr:   w = '{in_rdy: 1'b0, op: OP_ERR,   cond: C_ALWAYS,   target: StWait};
            default: w = '{in_rdy: 1'b0, op: OP_NONE,  cond: C_ALWAYS,   target: StWait};
        endcase
        return w;
    endfunction

    logic [UpcW-1:0] r_upc;
    logic [UpcW-1:0] n_upc;
    t_ctrl           ctrl;
    logic            take_jump;

    assign ctrl = step_word(r_upc);

    always_comb begin
        case (ctrl.cond)
            C_NEVER:    take_jump = 1'b0;
            C_ALWAYS:   take_jump = 1'b1;
            C_NO_START: take_jump = ~i_stat.start_acc;
            C_BAD:      take_jump = i_stat.bad;
            C_QEMPTY:   take_jump = i_stat.q_empty;
            C_CAND:     take_jump = i_stat.cand;
            default:    take_jump = 1'b1;
        endcase
        // A step that cannot hand its result to the output register holds.
        if (i_stat.stall) begin
            n_upc = r_upc;
        end else if (take_jump) begin
            n_upc = ctrl.target;
        end else begin
            n_upc = r_upc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= StWait;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_ctrl = ctrl;

endmodule

// ===== src/bfsam_dp.sv =====
// Search datapath: adjacency and queue memories, visited marks, output register.
module bfsam_dp #(
    parameter int MAX_VERTICES = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bfsam_pkg::t_ctrl            i_ctrl,
    output bfsam_pkg::t_stat            o_stat,
    input  logic                        i_in_valid,
    input  bfsam_pkg::t_in_item         i_in_data,
    input  logic [bfsam_pkg::CountW-1:0] i_count,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output bfsam_pkg::t_out_item        o_out_data
);
    import bfsam_pkg::*;

    localparam int Depth = (MAX_VERTICES < RowW) ? MAX_VERTICES : RowW;
    localparam int AW    = $clog2(Depth);
    localparam int PW    = AW + 1;
    localparam logic [CountW:0] MaxEff = (CountW + 1)'(MAX_VERTICES);

    logic [RowW-1:0] r_adj [Depth];
    logic [RowW-1:0] r_adj_q;
    logic [VtxW-1:0] r_queue [Depth];
    logic [VtxW-1:0] r_queue_q;

    logic [PW-1:0]   r_head, n_head;
    logic [PW-1:0]   r_tail, n_tail;
    logic [RowW-1:0] r_visited, n_visited;
    logic            r_out_valid, n_out_valid;
    logic [VtxW-1:0] r_start;
    logic [VtxW-1:0] r_pend;
    t_out_item       r_out_data;

    logic            in_acc, load_acc, start_acc, row_ok;
    logic [CountW:0] eff_count;
    logic            bad;
    logic [RowW-1:0] cnt_mask, cand_mask, low_bit;
    logic [VtxW-1:0] cand_idx;
    logic            has_cand, q_empty;
    logic            out_free, push_scan, need_push, push, stall;
    t_out_item       push_data;
    logic            q_we;
    logic [AW-1:0]   q_waddr;
    logic [VtxW-1:0] q_wdata;

    assign in_acc    = i_in_valid & i_ctrl.in_rdy;
    assign load_acc  = in_acc & (i_in_data.cmd == CMD_LOAD);
    assign start_acc = in_acc & (i_in_data.cmd == CMD_START);
    assign row_ok    = {2'b00, i_in_data.row_index} < MaxEff;

    assign eff_count = ({1'b0, i_count} > MaxEff) ? MaxEff : {1'b0, i_count};
    assign bad       = {2'b00, r_start} >= eff_count;

    always_comb begin
        for (int j = 0; j < RowW; j++) begin
            cnt_mask[j] = (CountW + 1)'(j) < eff_count;
        end
    end

    // Lowest unvisited neighbour of the current row, one per cycle unless the output register stalls.
    assign cand_mask = r_adj_q & ~r_visited & cnt_mask;
    assign low_bit   = cand_mask & (~cand_mask + 1'b1);
    assign has_cand  = |cand_mask;

    always_comb begin
        cand_idx = '0;
        for (int j = 0; j < RowW; j++) begin
            if (low_bit[j]) begin
                cand_idx = cand_idx | VtxW'(j);
            end
        end
    end

    assign q_empty = (r_head == r_tail);

    // The newest vertex waits in r_pend until the next one shows whether it was last.
    assign out_free  = ~r_out_valid | i_out_ready;
    assign push_scan = (i_ctrl.op == OP_SCAN) & has_cand;
    assign need_push = push_scan | (i_ctrl.op == OP_FIN) | (i_ctrl.op == OP_ERR);
    assign stall     = need_push & ~out_free;
    assign push      = need_push & out_free;

    always_comb begin
        case (i_ctrl.op)
            OP_FIN:  push_data = '{vertex: r_pend, last: 1'b1, error: 1'b0};
            OP_ERR:  push_data = '{vertex: '0, last: 1'b1, error: 1'b1};
            default: push_data = '{vertex: r_pend, last: 1'b0, error: 1'b0};
        endcase
    end

    always_comb begin
        q_we    = 1'b0;
        q_waddr = '0;
        q_wdata = r_start;
        if (i_ctrl.op == OP_INIT) begin
            q_we = 1'b1;
        end else if (push_scan && out_free) begin
            q_we    = 1'b1;
            q_waddr = r_tail[AW-1:0];
            q_wdata = cand_idx;
        end
    end

    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_visited   = r_visited;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (push) begin
            n_out_valid = 1'b1;
        end
        case (i_ctrl.op)
            OP_INIT: begin
                n_head    = '0;
                n_tail    = PW'(1);
                n_visited = RowW'(1) << r_start;
            end
            OP_QREAD: begin
                if (!q_empty) begin
                    n_head = r_head + 1'b1;
                end
            end
            OP_SCAN: begin
                if (push_scan && out_free) begin
                    n_tail    = r_tail + 1'b1;
                    n_visited = r_visited | low_bit;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_visited   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_visited   <= n_visited;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start_acc) begin
            r_start <= i_in_data.start_vertex;
        end
        if (i_ctrl.op == OP_INIT) begin
            r_pend <= r_start;
        end else if (push_scan && out_free) begin
            r_pend <= cand_idx;
        end
        if (push) begin
            r_out_data <= push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_acc && row_ok) begin
            r_adj[i_in_data.row_index[AW-1:0]] <= i_in_data.row_bits;
        end
        if (i_ctrl.op == OP_ROWRD) begin
            r_adj_q <= r_adj[r_queue_q[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            r_queue[q_waddr] <= q_wdata;
        end
        if (i_ctrl.op == OP_QREAD && !q_empty) begin
            r_queue_q <= r_queue[r_head[AW-1:0]];
        end
    end

    assign o_stat = '{start_acc: start_acc, bad: bad, q_empty: q_empty,
                      cand: has_cand, stall: stall};
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== src/bfs_adjacency_matrix.sv =====
// Top level of the breadth-first search block over an adjacency bit matrix.
//
// Input channel (i_in_valid / o_in_ready, payload i_in_data): a load item writes
// one adjacency row without leaving the wait step; a start item runs a whole search.
// Output channel (o_out_valid / i_out_ready, payload o_out_data): the visited
// vertices in breadth-first order, the final one flagged last. A start vertex
// not below the vertex count, capped at MAX_VERTICES, gives a single item with
// error and last set. The APB port holds vertex_count at address 0 (reset 32).
// A microcoded sequencer runs each search as accept, range check and init, then per
// dequeued vertex a queue read, a row read, a scan step repeated for each new
// neighbour and once more, a return step, then an empty queue read and a final step.
// A rejected start goes from the range check to the error step, which pushes its
// error item. Each vertex waits in r_pend until the next is found, so last can be
// flagged; the first push comes with a second vertex found or with the final step.
// The next item is accepted once the previous search has pushed its last
// result. When the receiver stalls, the output register holds and the
// sequencer waits at the step that has its next result ready.
// Reset clears the visited marks, queue pointers and output valid, and sets
// the vertex count to 32; adjacency rows hold no defined value until loaded.
module bfs_adjacency_matrix #(
    parameter int MAX_VERTICES = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  bfsam_pkg::t_in_item   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output bfsam_pkg::t_out_item  o_out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import bfsam_pkg::*;

    localparam logic RegVertexCount = 1'b0;

    logic [CountW-1:0] r_count;
    t_ctrl             ctrl;
    t_stat             stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CountReset;
        end else if (psel && penable && pwrite && paddr[2] == RegVertexCount) begin
            r_count <= pwdata[CountW-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == RegVertexCount) ? {{(32 - CountW){1'b0}}, r_count} : '0;

    bfsam_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    bfsam_dp #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .o_stat      (stat),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .i_count     (r_count),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    assign o_in_ready = ctrl.in_rdy;

endmodule

// ===== src/bfsam_chk.sv =====
// Port-level checks for the breadth-first search block, bound to the top level.
module bfsam_chk (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input bfsam_pkg::t_out_item  o_out_data
);
    import bfsam_pkg::*;

    // A stalled result item stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output item changed while stalled");

    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.error |-> o_out_data.last && o_out_data.vertex == '0)
        else $error("error item without last or with nonzero vertex");

    // Input ready is never high while a result other than the last of a search waits at the output.
    a_ready_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !(o_out_valid && !o_out_data.last))
        else $error("input ready while a search is still delivering");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind bfs_adjacency_matrix bfsam_chk u_bfsam_chk (.*);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the breadth-first search block over an adjacency bit matrix.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bfsam_pkg::*;

    localparam int ClkPeriod     = 10;
    localparam int ResetCycles   = 8;
    localparam int SettleCycles  = 40;
    localparam int ItemsPerPhase = 19;
    localparam int CycleLimit    = 2_000_000;
    localparam logic [2:0] AddrVertexCount = 3'd0;
    localparam t_out_item BadStart = '{vertex: 5'd0, last: 1'b1, error: 1'b1};

    typedef enum logic [1:0] {
        STEP_LOAD,
        STEP_START,
        STEP_COUNT
    } t_step_kind;

    // One directed row: arg is the row index, the start vertex or the count value.
    typedef struct packed {
        t_step_kind      kind;
        logic [5:0]      arg;
        logic [RowW-1:0] bits;
        logic            typed;
        t_out_item       want;
    } t_plan_entry;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Mirror of the block's state as the search sees it.
    logic [RowW-1:0]   adj_rows [32];
    logic [31:0]       rows_loaded = '0;
    logic [CountW-1:0] count_reg = CountReset;

    t_out_item visit_order [$];
    t_out_item expected_visits [$];
    t_out_item want_visit;

    bit          quiet_phase = 1'b0;
    int          stall_left = 0;
    int          mismatch_count = 0;
    int          results_checked = 0;
    int          error_results = 0;
    int          loads_sent = 0;
    int          starts_sent = 0;
    int          count_settings = 0;
    int unsigned cycle_count = 0;

    t_plan_entry directed_plan [24] = '{
        '{STEP_LOAD,  6'd0,  32'h0000_0000, 1'b0, '0},
        '{STEP_START, 6'd0,  32'h0,         1'b1, '{5'd0, 1'b1, 1'b0}},
        '{STEP_COUNT, 6'd4,  32'h0,         1'b0, '0},
        '{STEP_START, 6'd31, 32'h0,         1'b1, BadStart},
        '{STEP_START, 6'd4,  32'h0,         1'b1, BadStart},
        '{STEP_LOAD,  6'd0,  32'hFFFF_FFFF, 1'b0, '0},
        '{STEP_LOAD,  6'd1,  32'h0000_0003, 1'b0, '0},
        '{STEP_LOAD,  6'd2,  32'h0000_0000, 1'b0, '0},
        '{STEP_LOAD,  6'd3,  32'h8000_0001, 1'b0, '0},
        '{STEP_START, 6'd0,  32'h0,         1'b0, '0},
        '{STEP_START, 6'd3,  32'h0,         1'b0, '0},
        '{STEP_START, 6'd2,  32'h0,         1'b1, '{5'd2, 1'b1, 1'b0}},
        '{STEP_COUNT, 6'd1,  32'h0,         1'b0, '0},
        '{STEP_START, 6'd0,  32'h0,         1'b1, '{5'd0, 1'b1, 1'b0}},
        '{STEP_START, 6'd1,  32'h0,         1'b1, BadStart},
        '{STEP_COUNT, 6'd0,  32'h0,         1'b0, '0},
        '{STEP_START, 6'd0,  32'h0,         1'b1, BadStart},
        '{STEP_COUNT, 6'd63, 32'h0,         1'b0, '0},
        '{STEP_LOAD,  6'd31, 32'h0000_0001, 1'b0, '0},
        '{STEP_LOAD,  6'd0,  32'h8000_0000, 1'b0, '0},
        '{STEP_START, 6'd0,  32'h0,         1'b0, '0},
        '{STEP_START, 6'd31, 32'h0,         1'b0, '0},
        '{STEP_COUNT, 6'd32, 32'h0,         1'b0, '0},
        '{STEP_START, 6'd3,  32'h0,         1'b0, '0}
    };

    bfs_adjacency_matrix dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #(ClkPeriod / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("%0t: timeout with %0d visits outstanding", $realtime,
                     expected_visits.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver: checks each accepted item, then picks the next ready value.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left  <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                results_checked++;
                if (o_out_data.error) error_results++;
                if (expected_visits.size() == 0) begin
                    $display("%0t: unexpected item vertex %0d last %0b error %0b", $realtime,
                             o_out_data.vertex, o_out_data.last, o_out_data.error);
                    mismatch_count++;
                end else begin
                    want_visit = expected_visits.pop_front();
                    if (o_out_data.vertex !== want_visit.vertex
                            || o_out_data.last !== want_visit.last
                            || o_out_data.error !== want_visit.error) begin
                        $display("%0t: vertex/last/error expected %0d/%0b/%0b got %0d/%0b/%0b",
                                 $realtime, want_visit.vertex, want_visit.last,
                                 want_visit.error, o_out_data.vertex, o_out_data.last,
                                 o_out_data.error);
                        mismatch_count++;
                    end
                end
            end
            if (stall_left != 0) begin
                i_out_ready <= 1'b0;
                stall_left  <= stall_left - 1;
            end else if (!quiet_phase && $urandom_range(0, 99) < 12) begin
                i_out_ready <= 1'b0;
                stall_left  <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                           : $urandom_range(0, 3);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    function automatic int eff_count();
        return (count_reg > 6'd32) ? 32 : int'(count_reg);
    endfunction

    // Walks the graph from root in breadth-first order into visit_order and
    // returns the set of reached vertices, whose rows are all read.
    function automatic logic [31:0] walk_graph(input logic [VtxW-1:0] root);
        logic [31:0]     seen;
        logic [VtxW-1:0] frontier [$];
        logic [VtxW-1:0] v;
        t_out_item       visit;
        int              n;
        n        = eff_count();
        seen     = 32'b1 << root;
        frontier = {root};
        visit    = '{vertex: root, last: 1'b0, error: 1'b0};
        visit_order = {};
        visit_order.push_back(visit);
        while (frontier.size() != 0) begin
            v = frontier.pop_front();
            for (int c = 0; c < n; c++) begin
                if (adj_rows[v][c] && !seen[c]) begin
                    seen[c]      = 1'b1;
                    visit.vertex = VtxW'(c);
                    visit_order.push_back(visit);
                    frontier.push_back(VtxW'(c));
                end
            end
        end
        visit_order[visit_order.size() - 1].last = 1'b1;
        return seen;
    endfunction

    function automatic logic [RowW-1:0] random_row();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return 32'b1 << $urandom_range(0, 31);
            3, 4, 5: return $urandom & $urandom & $urandom;
            6, 7: return $urandom & $urandom;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(input t_in_item it);
        int gap;
        if (quiet_phase || $urandom_range(0, 99) < 60) gap = 0;
        else if ($urandom_range(0, 99) < 85) gap = $urandom_range(1, 3);
        else gap = $urandom_range(5, 30);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (it.cmd == CMD_START) starts_sent++;
        else loads_sent++;
    endtask

    task automatic send_load(input logic [VtxW-1:0] row, input logic [RowW-1:0] bits);
        t_in_item it;
        adj_rows[row]    = bits;
        rows_loaded[row] = 1'b1;
        it = '{cmd: CMD_LOAD, row_index: row, row_bits: bits,
               start_vertex: VtxW'($urandom)};
        send_item(it);
    endtask

    // Rows that the search would read but that were never written get loaded
    // first, so no search ever touches an undefined row.
    task automatic send_start(input logic [VtxW-1:0] root);
        t_in_item    it;
        logic [31:0] missing;
        if (int'(root) >= eff_count()) begin
            expected_visits.push_back(BadStart);
        end else begin
            missing = walk_graph(root) & ~rows_loaded;
            while (missing != 0) begin
                for (int r = 0; r < 32; r++) begin
                    if (missing[r]) send_load(VtxW'(r), random_row());
                end
                missing = walk_graph(root) & ~rows_loaded;
            end
            foreach (visit_order[j]) expected_visits.push_back(visit_order[j]);
        end
        it = '{cmd: CMD_START, row_index: VtxW'($urandom), row_bits: $urandom,
               start_vertex: root};
        send_item(it);
    endtask

    task automatic drain(input int settle);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_visits.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // Writes vertex_count once the block is idle, then reads it back.
    task automatic set_count(input logic [CountW-1:0] value);
        drain(SettleCycles);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= AddrVertexCount;
        pwdata  <= {26'b0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        count_reg = value;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== {26'b0, value}) begin
            $display("%0t: vertex_count read back expected %0d got %0d", $realtime,
                     value, prdata);
            mismatch_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        count_settings++;
    endtask

    initial begin
        t_plan_entry      entry;
        logic [CountW-1:0] count_plan [10];
        logic [VtxW-1:0]  root;
        int               n;

        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        foreach (adj_rows[r]) adj_rows[r] = '0;
        count_plan = '{6'd32, 6'd1, 6'd0, 6'd63, 6'd7, 6'd33, 6'd16, 6'd2, 6'd0, 6'd32};
        count_plan[8] = CountW'($urandom_range(3, 31));

        repeat (ResetCycles) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_plan[k]) begin
            entry = directed_plan[k];
            case (entry.kind)
                STEP_COUNT: set_count(entry.arg);
                STEP_LOAD: send_load(entry.arg[VtxW-1:0], entry.bits);
                default: begin
                    if (entry.typed) begin
                        expected_visits.push_back(entry.want);
                        send_item('{cmd: CMD_START, row_index: '0, row_bits: '0,
                                    start_vertex: entry.arg[VtxW-1:0]});
                    end else begin
                        send_start(entry.arg[VtxW-1:0]);
                    end
                end
            endcase
        end

        foreach (count_plan[p]) begin
            set_count(count_plan[p]);
            quiet_phase = (p % 3 == 1);
            n = eff_count();
            for (int i = 0; i < ItemsPerPhase; i++) begin
                // Let the pipeline run completely dry once, in the middle of the third phase.
                if (p == 2 && i == ItemsPerPhase / 2) drain(1);
                if ($urandom_range(0, 99) < 40) begin
                    if (n > 0 && $urandom_range(0, 99) < 70)
                        send_load(VtxW'($urandom_range(0, n - 1)), random_row());
                    else
                        send_load(VtxW'($urandom_range(0, 31)), random_row());
                end else begin
                    if (n == 0 || (n < 32 && $urandom_range(0, 99) < 15))
                        root = VtxW'($urandom_range(n, 31));
                    else
                        root = VtxW'($urandom_range(0, n - 1));
                    send_start(root);
                end
            end
        end

        quiet_phase = 1'b0;
        drain(SettleCycles);
        $display("Ran %0d row loads and %0d searches over %0d vertex-count settings,",
                 loads_sent, starts_sent, count_settings);
        $display("checking %0d visit items, %0d of them rejected starts.",
                 results_checked, error_results);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
